// File: design/vbh_pkg.sv
`default_nettype none
package vbh_pkg;
   localparam int BucketBitsDef = 16;
   localparam int EntriesPerBucketDef = 1;
   localparam int ExcessSizeDef = 4096;
   localparam int BlockEdgeDef = 8;
   localparam int VoxelBlocksDef = 1024;

   localparam logic [1:0] ACT_LOAD_ENTRY = 2'd0;
   localparam logic [1:0] ACT_LOAD_VOXEL = 2'd1;
   localparam logic [1:0] ACT_LOOKUP     = 2'd2;

   localparam logic [31:0] HASH_P1 = 32'd73856093;
   localparam logic [31:0] HASH_P2 = 32'd19349669;
   localparam logic [31:0] HASH_P3 = 32'd83492791;

   localparam logic signed [15:0] EMPTY_SDF_RESET = 16'sd32767;

   // One hash entry as stored: block position, excess link and block pointer.
   typedef struct packed {
      logic [15:0] pz;
      logic [15:0] py;
      logic [15:0] px;
      logic [12:0] link;
      logic [10:0] ptr;
   } entry_type;

   // Lookup request handed from the front end to the chain walker.
   typedef struct packed {
      logic signed [18:0] bx;
      logic signed [18:0] by;
      logic signed [18:0] bz;
      logic [31:0]        lin;
   } lkreq_type;
endpackage
`default_nettype wire

// File: design/voxel_block_hash_lookup_core.sv
`default_nettype none
// Voxel hash lookup core. Loads write the memories directly and do not raise
// busy. A lookup first hashes (coordinate split, then prime products), then
// reads one entry at a time from the hash table memory as the bucket and excess
// chain are walked, then reads the voxel memory on a hit and registers the result;
// busy is high meanwhile. The result appears on rsp_valid for one cycle right
// after busy falls and cannot be stalled.
module voxel_block_hash_lookup_core #(
   parameter int BUCKET_BITS        = vbh_pkg::BucketBitsDef,
   parameter int ENTRIES_PER_BUCKET = vbh_pkg::EntriesPerBucketDef,
   parameter int EXCESS_SIZE        = vbh_pkg::ExcessSizeDef,
   parameter int BLOCK_EDGE         = vbh_pkg::BlockEdgeDef,
   parameter int VOXEL_BLOCKS       = vbh_pkg::VoxelBlocksDef
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [1:0]          req_action,
   input  wire logic [18:0]         req_index,
   input  wire logic signed [18:0]  req_pos_x,
   input  wire logic signed [18:0]  req_pos_y,
   input  wire logic signed [18:0]  req_pos_z,
   input  wire logic signed [10:0]  req_block_pointer,
   input  wire logic [12:0]         req_excess_link,
   input  wire logic signed [15:0]  req_sdf_value,
   input  wire logic [7:0]          req_weight_value,
   input  wire logic                csr_we,
   input  wire logic signed [15:0]  csr_wdata,
   output logic                     rsp_valid,
   output logic                     rsp_found,
   output logic signed [15:0]       rsp_sdf_out,
   output logic [7:0]               rsp_weight_out
);
   import vbh_pkg::*;

   logic signed [15:0] empty_sdf_ff;

   // Empty voxel sdf register.
   always_ff @(posedge clock) begin
      if (reset) empty_sdf_ff <= EMPTY_SDF_RESET;
      else if (csr_we) empty_sdf_ff <= csr_wdata;
   end

   vbh_walk #(.BUCKET_BITS(BUCKET_BITS), .ENTRIES_PER_BUCKET(ENTRIES_PER_BUCKET),
      .EXCESS_SIZE(EXCESS_SIZE), .BLOCK_EDGE(BLOCK_EDGE), .VOXEL_BLOCKS(VOXEL_BLOCKS))
   u_walk (
      .clock(clock), .reset(reset), .start(start), .req_action(req_action),
      .req_index(req_index), .req_pos_x(req_pos_x), .req_pos_y(req_pos_y),
      .req_pos_z(req_pos_z), .req_block_pointer(req_block_pointer),
      .req_excess_link(req_excess_link), .req_sdf_value(req_sdf_value),
      .req_weight_value(req_weight_value), .empty_sdf(empty_sdf_ff), .busy(busy),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found), .rsp_sdf_out(rsp_sdf_out),
      .rsp_weight_out(rsp_weight_out));
endmodule
`default_nettype wire

// File: design/vbh_hash.sv
`default_nettype none
module vbh_hash #(
   parameter int BUCKET_BITS = 16,
   parameter int BLOCK_EDGE  = 8
) (
   input  wire logic                     clock,
   input  wire logic                     go,
   input  wire logic signed [18:0]       px,
   input  wire logic signed [18:0]       py,
   input  wire logic signed [18:0]       pz,
   output logic                          done,
   output logic [BUCKET_BITS-1:0]        bucket,
   output vbh_pkg::lkreq_type            req
);
   import vbh_pkg::*;

   localparam int EB = BLOCK_EDGE;

   logic signed [18:0] bx, by, bz;
   logic [31:0] lx, ly, lz;
   lkreq_type req_ff, req_in;
   logic [31:0] m1_ff, m2_ff, m3_ff;
   logic stage_ff;

   // Floor division of each axis by the block edge.
   function automatic logic signed [18:0] fdiv(input logic signed [18:0] p);
      logic signed [18:0] q;
      q = p / 19'(EB);
      if (p < 0 && q * 19'(EB) != p) q = q - 19'sd1;
      return q;
   endfunction

   always_comb begin
      bx = fdiv(px);
      by = fdiv(py);
      bz = fdiv(pz);
      lx = 32'(px - bx * 19'(EB));
      ly = 32'(py - by * 19'(EB));
      lz = 32'(pz - bz * 19'(EB));
      req_in.bx = bx;
      req_in.by = by;
      req_in.bz = bz;
      req_in.lin = lx + ly * 32'(EB) + lz * 32'(EB * EB);
   end

   // Stage one registers the split coordinate, stage two the products.
   always_ff @(posedge clock) begin
      if (go) req_ff <= req_in;
      m1_ff <= 32'(req_ff.bx) * HASH_P1;
      m2_ff <= 32'(req_ff.by) * HASH_P2;
      m3_ff <= 32'(req_ff.bz) * HASH_P3;
      stage_ff <= go;
      done <= stage_ff;
   end

   assign bucket = BUCKET_BITS'(m1_ff ^ m2_ff ^ m3_ff);
   assign req = req_ff;
endmodule
`default_nettype wire

// File: design/vbh_walk.sv
`default_nettype none
module vbh_walk #(
   parameter int BUCKET_BITS        = 16,
   parameter int ENTRIES_PER_BUCKET = 1,
   parameter int EXCESS_SIZE        = 4096,
   parameter int BLOCK_EDGE         = 8,
   parameter int VOXEL_BLOCKS       = 1024
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [1:0]           req_action,
   input  wire logic [18:0]          req_index,
   input  wire logic signed [18:0]   req_pos_x,
   input  wire logic signed [18:0]   req_pos_y,
   input  wire logic signed [18:0]   req_pos_z,
   input  wire logic signed [10:0]   req_block_pointer,
   input  wire logic [12:0]          req_excess_link,
   input  wire logic signed [15:0]   req_sdf_value,
   input  wire logic [7:0]           req_weight_value,
   input  wire logic signed [15:0]   empty_sdf,
   output logic                      busy,
   output logic                      rsp_valid,
   output logic                      rsp_found,
   output logic signed [15:0]        rsp_sdf_out,
   output logic [7:0]                rsp_weight_out
);
   import vbh_pkg::*;

   localparam int ORDERED = (1 << BUCKET_BITS) * ENTRIES_PER_BUCKET;
   localparam int TABLE   = ORDERED + EXCESS_SIZE;
   localparam int TW      = $clog2(TABLE);
   localparam int BV      = BLOCK_EDGE * BLOCK_EDGE * BLOCK_EDGE;
   localparam int VSIZE   = VOXEL_BLOCKS * BV;
   localparam int VW      = (VSIZE > 1) ? $clog2(VSIZE) : 1;
   localparam int EW      = (ENTRIES_PER_BUCKET > 1) ? $clog2(ENTRIES_PER_BUCKET) + 1 : 1;
   localparam int NW      = $clog2(EXCESS_SIZE + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_HASH  = 3'd1;
   localparam logic [2:0] ST_READ  = 3'd2;
   localparam logic [2:0] ST_CHECK = 3'd3;
   localparam logic [2:0] ST_VOX   = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   entry_type          table_mem [TABLE];
   logic [23:0]        voxel_mem [VSIZE];
   entry_type          ent_ff;
   logic [23:0]        vox_ff;

   logic [2:0]         st_ff, st_in;
   logic [TW-1:0]      slot_ff, slot_in;
   logic [EW-1:0]      ecnt_ff, ecnt_in;
   logic [NW-1:0]      ncnt_ff, ncnt_in;
   logic               inbkt_ff, inbkt_in;
   logic               hit_ff, hit_in;
   logic [VW-1:0]      vaddr_ff, vaddr_in;

   logic               hgo, hdone;
   logic [BUCKET_BITS-1:0] bucket;
   lkreq_type          lk;
   logic               accept, match;
   logic signed [10:0] eptr;

   assign accept = start && !busy;
   assign hgo = accept && req_action == ACT_LOOKUP;

   vbh_hash #(.BUCKET_BITS(BUCKET_BITS), .BLOCK_EDGE(BLOCK_EDGE)) u_hash (
      .clock(clock), .go(hgo), .px(req_pos_x), .py(req_pos_y), .pz(req_pos_z),
      .done(hdone), .bucket(bucket), .req(lk));

   // Loads write straight into the memories.
   always_ff @(posedge clock) begin
      if (accept && req_action == ACT_LOAD_ENTRY && 32'(req_index) < 32'(TABLE))
         table_mem[TW'(req_index)] <= '{pz: req_pos_z[15:0], py: req_pos_y[15:0],
            px: req_pos_x[15:0], link: req_excess_link, ptr: req_block_pointer};
      if (accept && req_action == ACT_LOAD_VOXEL && 32'(req_index) < 32'(VSIZE))
         voxel_mem[VW'(req_index)] <= {req_weight_value, req_sdf_value};
      ent_ff <= table_mem[slot_ff];
      vox_ff <= voxel_mem[vaddr_ff];
   end

   // Match test of the entry just read.
   always_comb begin
      eptr = signed'(ent_ff.ptr);
      match = signed'(ent_ff.px) == lk.bx && signed'(ent_ff.py) == lk.by &&
              signed'(ent_ff.pz) == lk.bz && eptr >= 0 &&
              32'(eptr) < 32'(VOXEL_BLOCKS);
   end

   // Sequencer: reads and checks one entry at a time along bucket, then excess chain.
   always_comb begin
      st_in = st_ff; slot_in = slot_ff; ecnt_in = ecnt_ff; ncnt_in = ncnt_ff;
      inbkt_in = inbkt_ff; hit_in = hit_ff; vaddr_in = vaddr_ff;
      case (st_ff)
         ST_IDLE: begin
            if (hgo) st_in = ST_HASH;
         end
         ST_HASH: begin
            if (hdone) begin
               slot_in = TW'(32'(bucket) * 32'(ENTRIES_PER_BUCKET));
               ecnt_in = '0; ncnt_in = '0; inbkt_in = 1'b1; hit_in = 1'b0;
               st_in = ST_READ;
            end
         end
         ST_READ: st_in = ST_CHECK;
         ST_CHECK: begin
            if (match) begin
               hit_in = 1'b1;
               vaddr_in = VW'(32'(eptr) * 32'(BV) + lk.lin);
               st_in = ST_VOX;
            end else if (inbkt_ff && 32'(ecnt_ff) + 1 < 32'(ENTRIES_PER_BUCKET)) begin
               ecnt_in = ecnt_ff + 1'b1;
               slot_in = slot_ff + 1'b1;
               st_in = ST_READ;
            end else if (ent_ff.link == '0 || 32'(ent_ff.link) - 1 >= 32'(EXCESS_SIZE)
                         || 32'(ncnt_ff) >= 32'(EXCESS_SIZE)) begin
               st_in = ST_OUT;
            end else begin
               inbkt_in = 1'b0;
               ncnt_in = ncnt_ff + 1'b1;
               slot_in = TW'(32'(ORDERED) + 32'(ent_ff.link) - 1);
               st_in = ST_READ;
            end
         end
         ST_VOX: st_in = ST_OUT;
         ST_OUT: st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         rsp_valid <= 1'b0;
      end else begin
         st_ff <= st_in;
         rsp_valid <= st_ff == ST_OUT;
      end
      slot_ff <= slot_in; ecnt_ff <= ecnt_in; ncnt_ff <= ncnt_in;
      inbkt_ff <= inbkt_in; hit_ff <= hit_in; vaddr_ff <= vaddr_in;
      if (st_ff == ST_OUT) begin
         rsp_found <= hit_ff;
         rsp_sdf_out <= hit_ff ? signed'(vox_ff[15:0]) : empty_sdf;
         rsp_weight_out <= hit_ff ? vox_ff[23:16] : 8'd0;
      end
   end

   assign busy = st_ff != ST_IDLE;
endmodule
`default_nettype wire

// File: design/vbh_checker.sv
`default_nettype none
module vbh_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       start,
   input wire logic       busy,
   input wire logic [1:0] req_action,
   input wire logic       rsp_valid,
   input wire logic       rsp_found,
   input wire logic [7:0] rsp_weight_out
);
   import vbh_pkg::*;

   // A lookup keeps the core busy on the next cycle.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action == ACT_LOOKUP |=> busy) else $error("lookup not busy");
   // Loads and other non-lookup actions cause no busy period.
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_action != ACT_LOOKUP |=> !busy) else $error("load busy");
   // A result follows the end of a busy period.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy)) else $error("stray result");
   // Not found means zero weight.
   a_miss_weight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_weight_out == 8'd0) else $error("miss weight");
endmodule

bind voxel_block_hash_lookup_core vbh_checker u_vbh_checker (
   .clock(clock), .reset(reset), .start(start), .busy(busy),
   .req_action(req_action), .rsp_valid(rsp_valid), .rsp_found(rsp_found),
   .rsp_weight_out(rsp_weight_out));
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
`default_nettype none
module tb;
   import vbh_pkg::*;

   localparam int BE = BlockEdgeDef;
   localparam int EPB = EntriesPerBucketDef;
   localparam int EXC = ExcessSizeDef;
   localparam int ORD = (1 << BucketBitsDef) * EPB;
   localparam int TABLE_SLOTS = ORD + EXC;
   localparam int BLK_VOX = BE * BE * BE;
   localparam int VOX_SLOTS = VoxelBlocksDef * BLK_VOX;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SETTLE = 20;

   // Action code that the block ignores.
   localparam logic [1:0] ACT_RESERVED = 2'd3;

   typedef struct packed {
      logic        found;
      logic [15:0] sdf;
      logic [7:0]  weight;
   } voxel_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_action = ACT_LOAD_ENTRY;
   logic [18:0] req_index = '0;
   logic signed [18:0] req_pos_x = '0;
   logic signed [18:0] req_pos_y = '0;
   logic signed [18:0] req_pos_z = '0;
   logic signed [10:0] req_block_pointer = '0;
   logic [12:0] req_excess_link = '0;
   logic signed [15:0] req_sdf_value = '0;
   logic [7:0] req_weight_value = '0;
   logic csr_we = 1'b0;
   logic signed [15:0] csr_wdata = '0;
   logic rsp_valid;
   logic rsp_found;
   logic signed [15:0] rsp_sdf_out;
   logic [7:0] rsp_weight_out;

   // Shadow copy of the hash table, the voxel store and the empty value.
   logic [47:0] shadow_pos [TABLE_SLOTS];
   logic [23:0] shadow_link [TABLE_SLOTS];
   bit shadow_pos_ok [TABLE_SLOTS];
   logic [23:0] shadow_voxel [VOX_SLOTS];
   bit shadow_voxel_ok [VOX_SLOTS];
   logic [15:0] shadow_empty = EMPTY_SDF_RESET;
   int next_excess = 0;

   voxel_answer_type answers_due [$];
   int idle_pct = 0;
   int items_sent = 0;
   int errors = 0;
   int mismatches = 0;
   int cycles = 0;

   voxel_block_hash_lookup_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_index(req_index),
      .req_pos_x(req_pos_x), .req_pos_y(req_pos_y), .req_pos_z(req_pos_z),
      .req_block_pointer(req_block_pointer), .req_excess_link(req_excess_link),
      .req_sdf_value(req_sdf_value), .req_weight_value(req_weight_value),
      .csr_we(csr_we), .csr_wdata(csr_wdata),
      .rsp_valid(rsp_valid), .rsp_found(rsp_found),
      .rsp_sdf_out(rsp_sdf_out), .rsp_weight_out(rsp_weight_out)
   );

   always #1 clock = ~clock;

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   // Every result is compared with the oldest pending answer.
   always @(posedge clock) begin
      voxel_answer_type want;
      if (!reset && rsp_valid) begin
         if (answers_due.size() == 0) begin
            errors++;
            $display("unexpected result found=%0d sdf=%0d weight=%0d",
                     rsp_found, rsp_sdf_out, rsp_weight_out);
         end else begin
            want = answers_due.pop_front();
            if (rsp_found !== want.found || rsp_sdf_out !== want.sdf ||
                rsp_weight_out !== want.weight) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected found=%0d sdf=%0d weight=%0d, got %0d %0d %0d",
                           want.found, $signed(want.sdf), want.weight,
                           rsp_found, rsp_sdf_out, rsp_weight_out);
            end
         end
      end
   end

   // Bucket base slot of a block coordinate.
   function automatic int bucket_of(int bx, int by, int bz);
      logic [31:0] h;
      h = (32'(bx) * HASH_P1) ^ (32'(by) * HASH_P2) ^ (32'(bz) * HASH_P3);
      h = h & ((32'd1 << BucketBitsDef) - 32'd1);
      return int'(h) * EPB;
   endfunction

   function automatic bit entry_hit(int slot, int bx, int by, int bz, output int ptr);
      logic signed [10:0] p;
      logic signed [15:0] cx, cy, cz;
      p = shadow_link[slot][10:0];
      cx = shadow_pos[slot][15:0];
      cy = shadow_pos[slot][31:16];
      cz = shadow_pos[slot][47:32];
      ptr = p;
      return int'(cx) == bx && int'(cy) == by && int'(cz) == bz &&
             ptr >= 0 && ptr < VoxelBlocksDef;
   endfunction

   // Walks bucket and excess chain; reports the first unwritten slot or voxel.
   function automatic void walk(input int px, input int py, input int pz,
                                output voxel_answer_type ans,
                                output int need_slot, output int need_vox);
      int p[3];
      int bk[3];
      int lc[3];
      int base, slot, ptr, lin, addr;
      int unsigned lnk;
      bit hit;
      p[0] = px;
      p[1] = py;
      p[2] = pz;
      for (int a = 0; a < 3; a++) begin
         bk[a] = p[a] / BE;
         if (p[a] < 0 && bk[a] * BE != p[a])
            bk[a]--;
         lc[a] = p[a] - bk[a] * BE;
      end
      lin = lc[0] + lc[1] * BE + lc[2] * BE * BE;
      base = bucket_of(bk[0], bk[1], bk[2]);
      ans = '0;
      need_slot = -1;
      need_vox = -1;
      hit = 0;
      lnk = 0;
      ptr = 0;
      for (int e = 0; e < EPB && !hit; e++) begin
         if (!shadow_pos_ok[base + e]) begin
            need_slot = base + e;
            return;
         end
         lnk = shadow_link[base + e][23:11];
         hit = entry_hit(base + e, bk[0], bk[1], bk[2], ptr);
      end
      for (int n = 0; n < EXC && !hit; n++) begin
         if (lnk == 0 || lnk - 1 >= EXC)
            break;
         slot = ORD + int'(lnk) - 1;
         if (!shadow_pos_ok[slot]) begin
            need_slot = slot;
            return;
         end
         hit = entry_hit(slot, bk[0], bk[1], bk[2], ptr);
         lnk = shadow_link[slot][23:11];
      end
      if (hit) begin
         addr = ptr * BLK_VOX + lin;
         if (!shadow_voxel_ok[addr]) begin
            need_vox = addr;
            return;
         end
         ans = {1'b1, shadow_voxel[addr][15:0], shadow_voxel[addr][23:16]};
      end else begin
         ans = {1'b0, shadow_empty, 8'd0};
      end
   endfunction

   function automatic int alloc_excess();
      while (next_excess < EXC && shadow_pos_ok[ORD + next_excess])
         next_excess++;
      return (next_excess < EXC) ? next_excess : -1;
   endfunction

   function automatic int rand_sdf();
      return int'($urandom_range(0, 65534)) - 32767;
   endfunction

   // Drives one item and returns at the edge that accepts it.
   task automatic send_item(input logic [1:0] act, input int idx, input int px,
                            input int py, input int pz, input int ptr, input int lnk,
                            input int sdf, input int wt);
      if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      start = 1'b1;
      req_action = act;
      req_index = idx[18:0];
      req_pos_x = px[18:0];
      req_pos_y = py[18:0];
      req_pos_z = pz[18:0];
      req_block_pointer = ptr[10:0];
      req_excess_link = lnk[12:0];
      req_sdf_value = sdf[15:0];
      req_weight_value = wt[7:0];
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   task automatic load_entry(input int slot, input int px, input int py, input int pz,
                             input int ptr, input int lnk);
      send_item(ACT_LOAD_ENTRY, slot, px, py, pz, ptr, lnk, rand_sdf(),
                $urandom_range(0, 255));
      if (slot >= 0 && slot < TABLE_SLOTS) begin
         shadow_pos[slot] = {16'(pz), 16'(py), 16'(px)};
         shadow_link[slot] = {13'(lnk), 11'(ptr)};
         shadow_pos_ok[slot] = 1;
      end
   endtask

   task automatic load_voxel(input int addr, input int sdf, input int wt);
      send_item(ACT_LOAD_VOXEL, addr, $urandom, $urandom, $urandom, $urandom,
                $urandom, sdf, wt);
      shadow_voxel[addr[18:0]] = {8'(wt), 16'(sdf)};
      shadow_voxel_ok[addr[18:0]] = 1;
   endtask

   // Entry of random content for a slot the next lookup would read.
   task automatic fill_slot(input int slot);
      int ptr, lnk, k, r;
      r = $urandom_range(0, 99);
      ptr = (r < 50) ? $urandom_range(0, 1023) : (r < 70) ? -1 : int'($urandom);
      r = $urandom_range(0, 99);
      lnk = 0;
      if (r >= 90) begin
         k = alloc_excess();
         lnk = (k < 0) ? 0 : k + 1;
      end else if (r >= 75) begin
         lnk = $urandom_range(EXC + 1, 8191);
      end
      load_entry(slot, $urandom, $urandom, $urandom, ptr, lnk);
   endtask

   // Lookup; first loads whatever it would read that was never written.
   task automatic look_up(input int px, input int py, input int pz);
      voxel_answer_type ans;
      int need_slot, need_vox;
      forever begin
         walk(px, py, pz, ans, need_slot, need_vox);
         if (need_slot >= 0)
            fill_slot(need_slot);
         else if (need_vox >= 0)
            load_voxel(need_vox, rand_sdf(), $urandom_range(0, 255));
         else
            break;
      end
      send_item(ACT_LOOKUP, $urandom, px, py, pz, $urandom, $urandom, $urandom, $urandom);
      answers_due = {answers_due, ans};
   endtask

   // Makes a block reachable, either in its bucket or at the head of the chain.
   task automatic place_block(input int bx, input int by, input int bz, input int ptr,
                              input bit in_chain);
      int b, k;
      logic [47:0] old_pos;
      logic [23:0] old_link;
      b = bucket_of(bx, by, bz);
      k = in_chain ? alloc_excess() : -1;
      if (k >= 0 && !shadow_pos_ok[b])
         load_entry(b, bx + 1, by, bz, $urandom, 0);
      old_pos = shadow_pos[b];
      old_link = shadow_pos_ok[b] ? shadow_link[b] : 24'd0;
      if (k >= 0) begin
         load_entry(ORD + k, {$urandom_range(0, 7), 16'(bx)}, by, {$urandom_range(0, 7),
                    16'(bz)}, ptr, old_link[23:11]);
         load_entry(b, $signed(old_pos[15:0]), $signed(old_pos[31:16]),
                    $signed(old_pos[47:32]), $signed(old_link[10:0]), k + 1);
      end else begin
         load_entry(b, {$urandom_range(0, 7), 16'(bx)}, by, bz, ptr, old_link[23:11]);
      end
   endtask

   // Waits until the block has answered everything and gone quiet.
   task automatic drain();
      @(negedge clock);
      start = 1'b0;
      do @(posedge clock); while (answers_due.size() != 0 || busy);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic set_empty_sdf(input int value);
      drain();
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = value[15:0];
      @(negedge clock);
      csr_we = 1'b0;
      shadow_empty = value[15:0];
   endtask

   // Directed cases: extremes, unallocated pointers, broken and looping chains.
   task automatic test_special_cases();
      int b, ka, kb;
      look_up(100, -100, 5);
      send_item(ACT_RESERVED, $urandom, $urandom, $urandom, $urandom, 0, 0, 0, 0);
      load_entry(TABLE_SLOTS, 1, 1, 1, 1, 0);
      load_entry(19'h7FFFF, 0, 0, 0, 0, 0);
      place_block(0, 0, 0, 5, 0);
      load_voxel(5 * BLK_VOX, -32767, 255);
      look_up(0, 0, 0);
      load_voxel(5 * BLK_VOX + BLK_VOX - 1, 32767, 0);
      look_up(BE - 1, BE - 1, BE - 1);
      place_block(-1, -1, -1, 1023, 1);
      look_up(-1, -1, -1);
      look_up(-BE, -BE, -BE);
      place_block(-32768, 32767, -32768, 0, 1);
      look_up(-262144, 262143, -262144);
      // Matching position but no allocated block.
      place_block(3, 3, 3, -1, 0);
      look_up(3 * BE, 3 * BE, 3 * BE);
      place_block(4, 4, 4, -1024, 1);
      look_up(4 * BE + 1, 4 * BE, 4 * BE);
      // Link past the end of the excess list.
      load_entry(bucket_of(9, 9, 9), 10, 9, 9, 7, EXC + 1);
      look_up(9 * BE, 9 * BE, 9 * BE);
      // A chain that loops between two excess slots and never matches.
      b = bucket_of(20, 20, 20);
      ka = alloc_excess();
      load_entry(ORD + ka, 21, 20, 20, 1, 0);
      kb = alloc_excess();
      load_entry(ORD + kb, 22, 20, 20, 2, ka + 1);
      load_entry(ORD + ka, 21, 20, 20, 1, kb + 1);
      load_entry(b, 23, 20, 20, 3, ka + 1);
      look_up(20 * BE, 20 * BE, 20 * BE);
      drain();
   endtask

   // Mostly well-formed block insertions followed by lookups, plus noise.
   task automatic test_random_traffic(input int count, input int pct);
      int goal, r, bx, by, bz, nlook;
      goal = items_sent + count;
      idle_pct = pct;
      while (items_sent < goal) begin
         r = $urandom_range(0, 99);
         if (r < 55) begin
            if ($urandom_range(0, 4) == 0) begin
               bx = $signed(16'($urandom));
               by = $signed(16'($urandom));
               bz = $signed(16'($urandom));
            end else begin
               bx = int'($urandom_range(0, 60)) - 30;
               by = int'($urandom_range(0, 60)) - 30;
               bz = int'($urandom_range(0, 60)) - 30;
            end
            place_block(bx, by, bz, $urandom_range(0, VoxelBlocksDef - 1),
                        $urandom_range(0, 99) < 40);
            nlook = $urandom_range(2, 4);
            repeat (nlook)
               look_up(bx * BE + int'($urandom_range(0, BE - 1)),
                       by * BE + int'($urandom_range(0, BE - 1)),
                       bz * BE + int'($urandom_range(0, BE - 1)));
         end else if (r < 70) begin
            look_up($signed(19'($urandom)), $signed(19'($urandom)), $signed(19'($urandom)));
         end else if (r < 80) begin
            load_entry($urandom_range(0, TABLE_SLOTS - 1), $urandom, $urandom, $urandom,
                       $urandom, ($urandom_range(0, 1) == 1) ? 0 :
                       $urandom_range(EXC + 1, 8191));
         end else if (r < 90) begin
            load_voxel($urandom_range(0, VOX_SLOTS - 1), rand_sdf(), $urandom_range(0, 255));
         end else if (r < 95) begin
            load_entry($urandom_range(TABLE_SLOTS, 19'h7FFFF), $urandom, $urandom,
                       $urandom, $urandom, $urandom);
         end else begin
            send_item(ACT_RESERVED, $urandom, $urandom, $urandom, $urandom, $urandom,
                      $urandom, $urandom, $urandom);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_special_cases();
      set_empty_sdf(-32767);
      test_random_traffic(700, 30);
      set_empty_sdf(32767);
      test_random_traffic(700, 65);
      set_empty_sdf(0);
      test_random_traffic(300, 0);
      set_empty_sdf(rand_sdf());
      test_random_traffic(300, 0);
      drain();
      if (errors == 0)
         $display("tb: clean");
      else
         $display("tb: errors");
      $finish;
   end
endmodule
`default_nettype wire
